>>> rtl/tpag_pkg.sv
package tpag_pkg;

	localparam int MAX_EXTENT = 4096;
	localparam int CNT_W      = $clog2(MAX_EXTENT);
	localparam int LEXT_W     = $clog2(MAX_EXTENT + 1);

	localparam int EXT_W      = 13;
	localparam int RANK_W     = 3;
	localparam int ORDER_W    = 5;
	localparam int IDX_W      = 48;
	localparam int NUM_AXES   = 4;
	localparam int AXIS_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_C = 3'd5;

	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	// stride and level tables follow a register write through the stride2_q, stride3_q and level registers
	localparam int SETTLE_CYCLES = 3;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	localparam int NUM_ORDERS = 24;
	localparam int ROW_W      = 5;

	// source axis walked by each output level, level l in bits [2l+1:2l]
	localparam logic [2*NUM_AXES-1:0] PERM_TABLE [NUM_ORDERS] = '{
		8'hE4, 8'hE1, 8'hD8, 8'hD2, 8'hC9, 8'hC6,
		8'hB4, 8'hB1, 8'h9C, 8'h93, 8'h8D, 8'h87,
		8'h78, 8'h72, 8'h6C, 8'h63, 8'h4E, 8'h4B,
		8'h39, 8'h36, 8'h2D, 8'h27, 8'h1E, 8'h1B
	};

	typedef enum logic {
		KIND_STEP,
		KIND_RESTART
	} item_kind_t;

	typedef struct packed {
		logic       valid;
		item_kind_t kind;
	} fq_t;

	typedef struct packed {
		logic                               restart;
		logic                               bad;
		logic [NUM_AXES-1:0][LEXT_W-1:0]    ext;
		logic [NUM_AXES-1:0][IDX_W-1:0]     stride;
	} walk_cfg_t;

endpackage

>>> rtl/tpag_cfg.sv
module tpag_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpag_pkg::CFG_DATA_W-1:0] cfg_data,
	output tpag_pkg::walk_cfg_t             walk,
	output logic                            busy
);
	import tpag_pkg::*;

	localparam logic [ROW_W-1:0] RANK3_ROW_BASE = ROW_W'(6);

	logic [RANK_W-1:0]                 rank_q;
	logic [ORDER_W-1:0]                order_q;
	logic [NUM_AXES-1:0][EXT_W-1:0]    ext_q;
	logic [SETTLE_W-1:0]               settle_q;

	logic [RANK_W-1:0]                 rank_e;
	logic [NUM_AXES-1:0][LEXT_W-1:0]   ext_e;
	logic [ORDER_W-1:0]                limit;
	logic                              bad;
	logic [ORDER_W-1:0]                code;
	logic [ROW_W-1:0]                  row;
	logic [NUM_AXES-1:0][IDX_W-1:0]    stride;
	logic [AXIS_W-1:0]                 axis [NUM_AXES];

	logic [2*LEXT_W-1:0]               stride2_q;
	logic [3*LEXT_W-1:0]               stride3_q;
	logic [NUM_AXES-1:0][LEXT_W-1:0]   lvl_ext_q;
	logic [NUM_AXES-1:0][IDX_W-1:0]    lvl_stride_q;
	logic                              bad_q;

	function automatic logic [LEXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
		logic [LEXT_W-1:0] r;
		if (v == '0) begin
			r = LEXT_W'(1);
		end else if (int'(v) > MAX_EXTENT) begin
			r = LEXT_W'(MAX_EXTENT);
		end else begin
			r = LEXT_W'(v);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= RANK_W'(NUM_AXES);
			order_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ext_q[i] <= EXT_W'(1);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANK:     rank_q   <= cfg_data[RANK_W-1:0];
				REG_ORDER:    order_q  <= cfg_data[ORDER_W-1:0];
				REG_EXTENT_W: ext_q[0] <= cfg_data[EXT_W-1:0];
				REG_EXTENT_H: ext_q[1] <= cfg_data[EXT_W-1:0];
				REG_EXTENT_D: ext_q[2] <= cfg_data[EXT_W-1:0];
				REG_EXTENT_C: ext_q[3] <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else if (cfg_we) begin
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	always_comb begin
		if (rank_q == '0) begin
			rank_e = RANK_W'(1);
		end else if (rank_q > RANK_W'(NUM_AXES)) begin
			rank_e = RANK_W'(NUM_AXES);
		end else begin
			rank_e = rank_q;
		end

		// unused axes collapse to extent one; c joins at rank 3, d at rank 4
		ext_e[0] = clamp_extent(ext_q[0]);
		ext_e[1] = (rank_e >= RANK_W'(2)) ? clamp_extent(ext_q[1]) : LEXT_W'(1);
		ext_e[2] = (rank_e >= RANK_W'(4)) ? clamp_extent(ext_q[2]) : LEXT_W'(1);
		ext_e[3] = (rank_e >= RANK_W'(3)) ? clamp_extent(ext_q[3]) : LEXT_W'(1);

		case (rank_e)
			RANK_W'(1): limit = ORDER_W'(1);
			RANK_W'(2): limit = ORDER_W'(2);
			RANK_W'(3): limit = ORDER_W'(6);
			default:    limit = ORDER_W'(NUM_ORDERS);
		endcase
		bad  = order_q >= limit;
		code = bad ? '0 : order_q;
		// rank 3 reuses the rank 4 rows that keep d outermost
		row  = (rank_e == RANK_W'(3)) ? ROW_W'(code) + RANK3_ROW_BASE : ROW_W'(code);
		if (row > ROW_W'(NUM_ORDERS - 1)) begin
			row = '0;
		end

		stride[0] = IDX_W'(1);
		stride[1] = IDX_W'(ext_e[0]);
		stride[2] = IDX_W'(stride2_q);
		stride[3] = IDX_W'(stride3_q);

		for (int l = 0; l < NUM_AXES; l++) begin
			axis[l] = PERM_TABLE[row][AXIS_W*l +: AXIS_W];
		end
	end

	always_ff @(posedge clk) begin
		stride2_q <= (2*LEXT_W)'(ext_e[0]) * (2*LEXT_W)'(ext_e[1]);
		stride3_q <= (3*LEXT_W)'(stride2_q) * (3*LEXT_W)'(ext_e[2]);
		for (int l = 0; l < NUM_AXES; l++) begin
			lvl_ext_q[l]    <= ext_e[axis[l]];
			lvl_stride_q[l] <= stride[axis[l]];
		end
		bad_q <= bad;
	end

	always_comb begin
		walk.restart = cfg_we && (cfg_index inside {[REG_RANK:REG_EXTENT_C]});
		walk.bad     = bad_q;
		walk.ext     = lvl_ext_q;
		walk.stride  = lvl_stride_q;
	end

	assign busy = cfg_we || (settle_q != '0);

endmodule

>>> rtl/tpag_front.sv
module tpag_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic          restart,
	input  logic          busy,
	output tpag_pkg::fq_t head,
	input  logic          pop
);
	import tpag_pkg::*;

	item_kind_t           kind_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0]  wr_ptr_q;
	logic [FQ_PTR_W-1:0]  rd_ptr_q;
	logic [FQ_CNT_W-1:0]  count_q;
	logic                 push;

	function automatic logic [FQ_PTR_W-1:0] ptr_next(input logic [FQ_PTR_W-1:0] p);
		logic [FQ_PTR_W-1:0] n;
		if (p == FQ_PTR_W'(FQ_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + FQ_PTR_W'(1);
		end
		return n;
	endfunction

	assign item_stall = (count_q == FQ_CNT_W'(FQ_DEPTH)) || busy;
	assign push       = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= restart ? KIND_RESTART : KIND_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FQ_CNT_W'(1);
				2'b01:   count_q <= count_q - FQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = count_q != '0;
	assign head.kind  = kind_q[rd_ptr_q];

endmodule

>>> rtl/tpag_back.sv
module tpag_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpag_pkg::fq_t               head,
	output logic                        pop,
	input  tpag_pkg::walk_cfg_t         walk,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [tpag_pkg::IDX_W-1:0]  source_index,
	output logic [tpag_pkg::IDX_W-1:0]  dest_index,
	output logic                        last,
	output logic                        bad_order
);
	import tpag_pkg::*;

	// base_q[l]: source index where every level below l sits at zero
	logic [NUM_AXES-1:0][CNT_W-1:0]  cnt_q;
	logic [NUM_AXES-1:0][IDX_W-1:0]  base_q;
	logic [IDX_W-1:0]                pos_q;

	logic                            valid_q;
	logic [IDX_W-1:0]                src_q;
	logic [IDX_W-1:0]                dst_q;
	logic                            last_q;
	logic                            bad_q;

	logic                            restart_now;
	logic [NUM_AXES-1:0][CNT_W-1:0]  cnt_e;
	logic [NUM_AXES-1:0][IDX_W-1:0]  base_e;
	logic [IDX_W-1:0]                pos_e;
	logic [NUM_AXES-1:0]             step_ok;
	logic                            last_now;
	logic [AXIS_W-1:0]               sel;
	logic [IDX_W-1:0]                next_base;
	logic [NUM_AXES-1:0][CNT_W-1:0]  cnt_n;
	logic [NUM_AXES-1:0][IDX_W-1:0]  base_n;
	logic [IDX_W-1:0]                pos_n;

	assign pop = head.valid && (!valid_q || !result_stall);

	always_comb begin
		restart_now = head.kind == KIND_RESTART;
		cnt_e  = restart_now ? '0 : cnt_q;
		base_e = restart_now ? '0 : base_q;
		pos_e  = restart_now ? '0 : pos_q;

		for (int l = 0; l < NUM_AXES; l++) begin
			step_ok[l] = ((LEXT_W+1)'(cnt_e[l]) + (LEXT_W+1)'(1)) < (LEXT_W+1)'(walk.ext[l]);
		end
		last_now = ~|step_ok;

		// lowest level that still has room takes the step
		sel = '0;
		for (int l = NUM_AXES - 1; l >= 0; l--) begin
			if (step_ok[l]) begin
				sel = AXIS_W'(l);
			end
		end
		next_base = base_e[sel] + walk.stride[sel];

		for (int l = 0; l < NUM_AXES; l++) begin
			if (last_now) begin
				cnt_n[l]  = '0;
				base_n[l] = '0;
			end else if (AXIS_W'(l) < sel) begin
				cnt_n[l]  = '0;
				base_n[l] = next_base;
			end else if (AXIS_W'(l) == sel) begin
				cnt_n[l]  = cnt_e[l] + CNT_W'(1);
				base_n[l] = next_base;
			end else begin
				cnt_n[l]  = cnt_e[l];
				base_n[l] = base_e[l];
			end
		end
		pos_n = last_now ? '0 : pos_e + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			base_q <= '0;
			pos_q  <= '0;
		end else if (walk.restart) begin
			cnt_q  <= '0;
			base_q <= '0;
			pos_q  <= '0;
		end else if (pop) begin
			cnt_q  <= cnt_n;
			base_q <= base_n;
			pos_q  <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			src_q  <= base_e[0];
			dst_q  <= pos_e;
			last_q <= last_now;
			bad_q  <= walk.bad;
		end
	end

	assign result_valid = valid_q;
	assign source_index = src_q;
	assign dest_index   = dst_q;
	assign last         = last_q;
	assign bad_order    = bad_q;

endmodule

>>> rtl/tensor_permute_address_gen_core.sv
// channel  | handshake                   | payload
// config   | cfg_we                      | cfg_index, cfg_data
// item in  | item_valid / item_stall     | restart
// result   | result_valid / result_stall | source_index, dest_index, last, bad_order
//
// One word in and one word out per cycle while item_stall and result_stall stay low; a taken word
// passes through a two-entry queue ahead of the counter stage into the result register.
// Each step is one 48-bit add of a level stride onto a held per-level base index.
// After reset and after every config write the input stalls while the stride multipliers
// and the level table settle; a config write to registers 0 to 5 restarts the walk.
// A result held by result_stall keeps its word; the queue keeps taking input until full.
module tensor_permute_address_gen_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpag_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            restart,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [tpag_pkg::IDX_W-1:0]      source_index,
	output logic [tpag_pkg::IDX_W-1:0]      dest_index,
	output logic                            last,
	output logic                            bad_order
);
	import tpag_pkg::*;

	walk_cfg_t walk;
	fq_t       head;
	logic      busy;
	logic      pop;

	tpag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.walk      (walk),
		.busy      (busy)
	);

	tpag_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.restart    (restart),
		.busy       (busy),
		.head       (head),
		.pop        (pop)
	);

	tpag_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.walk         (walk),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.source_index (source_index),
		.dest_index   (dest_index),
		.last         (last),
		.bad_order    (bad_order)
	);

endmodule

>>> rtl/tpag_checker.sv
module tpag_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            item_stall,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [tpag_pkg::IDX_W-1:0]      source_index,
	input  logic [tpag_pkg::IDX_W-1:0]      dest_index,
	input  logic                            last
);
	import tpag_pkg::*;

	logic             out_acc;
	logic             prev_valid_q;
	logic             prev_last_q;
	logic [IDX_W-1:0] prev_dest_q;

	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_last_q  <= 1'b0;
			prev_dest_q  <= '0;
		end else if (out_acc) begin
			prev_valid_q <= 1'b1;
			prev_last_q  <= last;
			prev_dest_q  <= dest_index;
		end
	end

	// word after the final element starts the tensor again
	a_wrap_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q && prev_last_q |-> dest_index == '0)
		else $error("walk did not wrap to the first element after last");

	// output position only ever advances by one or restarts
	a_dest_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q && !prev_last_q && dest_index != '0
		|-> dest_index == prev_dest_q + IDX_W'(1))
		else $error("dest_index skipped or repeated");

	// tables are rebuilt after a register write, so input must hold off
	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> item_stall)
		else $error("input taken while tables settle");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall
		|=> result_valid && $stable(source_index) && $stable(dest_index))
		else $error("stalled result word changed");

endmodule

bind tensor_permute_address_gen_core tpag_checker u_tpag_checker (.*);

>>> tb/sv/tensor_permute_address_gen_core_tb.sv
module tensor_permute_address_gen_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_WORDS = 850;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 90;

	localparam logic [tpag_pkg::CFG_IDX_W-1:0] SPARE_REG_A = 3'd6;
	localparam logic [tpag_pkg::CFG_IDX_W-1:0] SPARE_REG_B = 3'd7;

	localparam bit [1:0] AX_W = 2'd0;
	localparam bit [1:0] AX_H = 2'd1;
	localparam bit [1:0] AX_D = 2'd2;
	localparam bit [1:0] AX_C = 2'd3;

	typedef struct packed {
		logic [tpag_pkg::IDX_W-1:0] source;
		logic [tpag_pkg::IDX_W-1:0] dest;
		logic                       last;
		logic                       bad;
	} address_word_t;

	class address_walk_checker;
		bit [tpag_pkg::RANK_W-1:0]  rank_reg;
		bit [tpag_pkg::ORDER_W-1:0] order_reg;
		bit [tpag_pkg::EXT_W-1:0]   extent_reg [4];
		int unsigned                level_count [4];
		bit [tpag_pkg::IDX_W-1:0]   position;
		address_word_t              expected_addrs [$];
		int unsigned mismatches, words_in, results_out;
		int unsigned ends_seen, bad_seen, restarts_seen, settings;

		function new();
			rank_reg = 3'd4;
			order_reg = '0;
			foreach (extent_reg[i]) extent_reg[i] = 13'd1;
			restart_walk();
		endfunction

		function void restart_walk();
			foreach (level_count[i]) level_count[i] = 0;
			position = '0;
		endfunction

		function void note_config(logic [tpag_pkg::CFG_IDX_W-1:0] idx,
				logic [tpag_pkg::CFG_DATA_W-1:0] data);
			case (idx)
			tpag_pkg::REG_RANK:     rank_reg = data[2:0];
			tpag_pkg::REG_ORDER:    order_reg = data[4:0];
			tpag_pkg::REG_EXTENT_W: extent_reg[AX_W] = data;
			tpag_pkg::REG_EXTENT_H: extent_reg[AX_H] = data;
			tpag_pkg::REG_EXTENT_D: extent_reg[AX_D] = data;
			tpag_pkg::REG_EXTENT_C: extent_reg[AX_C] = data;
			default: return;
			endcase
			restart_walk();
		endfunction

		function int unsigned clamp_extent(bit [tpag_pkg::EXT_W-1:0] v);
			if (v == 0) return 1;
			if (v > tpag_pkg::MAX_EXTENT) return tpag_pkg::MAX_EXTENT;
			return v;
		endfunction

		// source axis of each level, slowest level first
		function bit [7:0] level_axes(int unsigned row);
			case (row)
			0:  return {AX_C, AX_D, AX_H, AX_W};
			1:  return {AX_C, AX_D, AX_W, AX_H};
			2:  return {AX_C, AX_H, AX_D, AX_W};
			3:  return {AX_C, AX_H, AX_W, AX_D};
			4:  return {AX_C, AX_W, AX_D, AX_H};
			5:  return {AX_C, AX_W, AX_H, AX_D};
			6:  return {AX_D, AX_C, AX_H, AX_W};
			7:  return {AX_D, AX_C, AX_W, AX_H};
			8:  return {AX_D, AX_H, AX_C, AX_W};
			9:  return {AX_D, AX_H, AX_W, AX_C};
			10: return {AX_D, AX_W, AX_C, AX_H};
			11: return {AX_D, AX_W, AX_H, AX_C};
			12: return {AX_H, AX_C, AX_D, AX_W};
			13: return {AX_H, AX_C, AX_W, AX_D};
			14: return {AX_H, AX_D, AX_C, AX_W};
			15: return {AX_H, AX_D, AX_W, AX_C};
			16: return {AX_H, AX_W, AX_C, AX_D};
			17: return {AX_H, AX_W, AX_D, AX_C};
			18: return {AX_W, AX_C, AX_D, AX_H};
			19: return {AX_W, AX_C, AX_H, AX_D};
			20: return {AX_W, AX_D, AX_C, AX_H};
			21: return {AX_W, AX_D, AX_H, AX_C};
			22: return {AX_W, AX_H, AX_C, AX_D};
			23: return {AX_W, AX_H, AX_D, AX_C};
			default: return {AX_C, AX_D, AX_H, AX_W};
			endcase
		endfunction

		function void note_word(bit restart_req);
			int unsigned     eff_rank, limit, row, a;
			int unsigned     ext [4];
			longint unsigned stride [4];
			longint unsigned src;
			bit              bad, at_end, carry;
			bit [7:0]        axes;
			address_word_t   e;

			eff_rank = rank_reg;
			if (eff_rank == 0) eff_rank = 1;
			if (eff_rank > 4) eff_rank = 4;
			ext[AX_W] = clamp_extent(extent_reg[AX_W]);
			ext[AX_H] = (eff_rank >= 2) ? clamp_extent(extent_reg[AX_H]) : 1;
			ext[AX_D] = (eff_rank >= 4) ? clamp_extent(extent_reg[AX_D]) : 1;
			ext[AX_C] = (eff_rank >= 3) ? clamp_extent(extent_reg[AX_C]) : 1;
			stride[AX_W] = 1;
			stride[AX_H] = ext[AX_W];
			stride[AX_D] = stride[AX_H] * ext[AX_H];
			stride[AX_C] = stride[AX_D] * ext[AX_D];
			case (eff_rank)
			1: limit = 1;
			2: limit = 2;
			3: limit = 6;
			default: limit = 24;
			endcase
			bad = (order_reg >= limit);
			row = bad ? 0 : order_reg;
			// rank 3 codes use the rows that keep d outermost
			if (eff_rank == 3) row += 6;
			if (restart_req) begin
				restart_walk();
				restarts_seen++;
			end
			axes = level_axes(row);
			src = 0;
			at_end = 1'b1;
			for (int lvl = 0; lvl < 4; lvl++) begin
				a = axes[2*lvl +: 2];
				src += level_count[lvl] * stride[a];
				if (level_count[lvl] + 1 < ext[a]) at_end = 1'b0;
			end
			e.source = src[tpag_pkg::IDX_W-1:0];
			e.dest = position;
			e.last = at_end;
			e.bad = bad;
			expected_addrs.push_back(e);
			words_in++;
			if (at_end) ends_seen++;
			if (bad) bad_seen++;
			if (at_end) begin
				restart_walk();
			end else begin
				position++;
				carry = 1'b1;
				for (int lvl = 0; lvl < 4; lvl++) begin
					a = axes[2*lvl +: 2];
					if (carry) begin
						if (level_count[lvl] + 1 < ext[a]) begin
							level_count[lvl]++;
							carry = 1'b0;
						end else begin
							level_count[lvl] = 0;
						end
					end
				end
			end
		endfunction

		function void check_result(logic [tpag_pkg::IDX_W-1:0] src,
				logic [tpag_pkg::IDX_W-1:0] dst, logic lst, logic bad);
			address_word_t e;

			results_out++;
			if (expected_addrs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with nothing outstanding: source %0d dest %0d",
						$time, src, dst);
				return;
			end
			e = expected_addrs.pop_front();
			if (src !== e.source || dst !== e.dest || lst !== e.last || bad !== e.bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: word %0d: source %0d exp %0d, dest %0d exp %0d, %s",
						$time, results_out, src, e.source, dst, e.dest,
						$sformatf("last %b exp %b, bad_order %b exp %b",
							lst, e.last, bad, e.bad));
			end
		endfunction

		function int unsigned pending();
			return expected_addrs.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tpag_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tpag_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_stall;
	logic                            restart = 1'b0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic [tpag_pkg::IDX_W-1:0]      source_index;
	logic [tpag_pkg::IDX_W-1:0]      dest_index;
	logic                            last;
	logic                            bad_order;

	bit          no_gaps;
	bit          hold_req;
	int unsigned holds_done;

	address_walk_checker walk = new();

	tensor_permute_address_gen_core dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			walk.check_result(source_index, dest_index, last, bad_order);
	end

	initial begin : result_side
		int unsigned hold_left;

		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
				holds_done++;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !no_gaps && $urandom_range(0, 99) < 19;
			end
		end
	end

	initial begin : watchdog
		int unsigned dead_cycles;

		dead_cycles = 0;
		while (dead_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
		$display("tensor_permute_address_gen_core verification failed");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(bit rst);
		while (!no_gaps && $urandom_range(0, 99) < 19) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		restart <= rst;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		walk.note_word(rst);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		while (walk.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic end_burst();
		item_valid <= 1'b0;
		wait_drain();
	endtask

	task automatic write_reg(logic [tpag_pkg::CFG_IDX_W-1:0] idx,
			logic [tpag_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		walk.note_config(idx, data);
		@(negedge clk);
	endtask

	task automatic config_all(logic [12:0] rank_val, logic [12:0] order_val,
			logic [12:0] ew, logic [12:0] eh, logic [12:0] ed, logic [12:0] ec);
		write_reg(tpag_pkg::REG_RANK, rank_val);
		write_reg(tpag_pkg::REG_ORDER, order_val);
		write_reg(tpag_pkg::REG_EXTENT_W, ew);
		write_reg(tpag_pkg::REG_EXTENT_H, eh);
		write_reg(tpag_pkg::REG_EXTENT_D, ed);
		write_reg(tpag_pkg::REG_EXTENT_C, ec);
		cfg_we <= 1'b0;
		walk.settings++;
	endtask

	task automatic run_directed();
		// reset state is a single element tensor, so every word is the last
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b0);
		end_burst();
		// rank field 0 acts as rank 1; upper data bits and unused axes ignored
		config_all(13'h1FF8, 13'd0, 13'd3, 13'd5, 13'd5, 13'd5);
		repeat (4) send_word(1'b0);
		end_burst();
		// rank 7 acts as 4, extent 0 as 1
		config_all(13'd7, 13'd23, 13'd2, 13'd1, 13'd2, 13'd0);
		repeat (2) send_word(1'b0);
		send_word(1'b1);
		send_word(1'b0);
		end_burst();
		// rank 3, order wch; d extent has no effect
		config_all(13'd3, 13'd4, 13'd2, 13'd2, 13'd7, 13'd2);
		repeat (4) send_word(1'b0);
		end_burst();
		// code 2 out of range at rank 2: identity walk, bad_order set
		config_all(13'd2, 13'h1FE2, 13'd2, 13'd2, 13'd1, 13'd1);
		repeat (3) send_word(1'b0);
		end_burst();
		// full size w, oversize h clamps to the maximum
		config_all(13'd2, 13'd1, 13'd4096, 13'h1FFF, 13'd1, 13'd1);
		repeat (3) send_word(1'b0);
		end_burst();
		// writes to indexes past the register list leave the walk alone
		config_all(13'd4, 13'd22, 13'd2, 13'd2, 13'd2, 13'd2);
		repeat (2) send_word(1'b0);
		end_burst();
		write_reg(SPARE_REG_A, 13'h1555);
		write_reg(SPARE_REG_B, 13'h0AAA);
		cfg_we <= 1'b0;
		repeat (2) send_word(1'b0);
		end_burst();
	endtask

	task automatic random_setting();
		logic [12:0] rank_val, order_val;
		logic [12:0] ext_val [4];
		int unsigned eff, span, pick;

		rank_val = 13'($urandom_range(1, 4));
		if ($urandom_range(0, 9) == 0)
			rank_val = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'($urandom_range(5, 7));
		eff = (rank_val == 0) ? 1 : (rank_val > 4) ? 4 : rank_val;
		span = (eff == 1) ? 1 : (eff == 2) ? 2 : (eff == 3) ? 6 : 24;
		order_val = 13'($urandom_range(0, span - 1));
		if ($urandom_range(0, 6) == 0)
			order_val = 13'($urandom_range(0, 31));
		if ($urandom_range(0, 2) == 0) begin
			rank_val[12:3] = 10'($urandom);
			order_val[12:5] = 8'($urandom);
		end
		// mostly tiny tensors so the walk wraps often
		foreach (ext_val[i]) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				ext_val[i] = 13'($urandom_range(1, 3));
			else if (pick < 84)
				ext_val[i] = 13'($urandom_range(4, 9));
			else if (pick < 91)
				ext_val[i] = 13'd0;
			else if (pick < 96)
				ext_val[i] = 13'($urandom_range(4090, 4096));
			else
				ext_val[i] = 13'($urandom_range(4097, 8191));
		end
		if ($urandom_range(0, 4) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? SPARE_REG_A : SPARE_REG_B, 13'($urandom));
		config_all(rank_val, order_val, ext_val[0], ext_val[1], ext_val[2], ext_val[3]);
	endtask

	initial begin : stimulus
		int unsigned burst;
		bit          hold_sent;

		hold_sent = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		while (walk.words_in < TOTAL_WORDS) begin
			random_setting();
			burst = $urandom_range(15, 60);
			// long receiver hold-off while words keep coming
			if (!hold_sent && walk.words_in >= 500) begin
				hold_req = 1'b1;
				hold_sent = 1'b1;
				burst = 60;
			end
			repeat (burst) begin
				if (walk.words_in == 300) no_gaps = 1'b1;
				if (walk.words_in == 440) no_gaps = 1'b0;
				if (walk.words_in == 680) begin
					item_valid <= 1'b0;
					wait_drain();
				end
				send_word($urandom_range(0, 99) < 6);
			end
			end_burst();
		end
		repeat (20) @(posedge clk);
		$display("Walked %0d words into %0d results over %0d register settings, %0d hold-off(s);",
			walk.words_in, walk.results_out, walk.settings, holds_done);
		$display("saw %0d tensor ends, %0d bad order codes, %0d restarts; %0d mismatches.",
			walk.ends_seen, walk.bad_seen, walk.restarts_seen, walk.mismatches);
		if (walk.mismatches == 0 && walk.pending() == 0)
			$display("tensor_permute_address_gen_core verification clean");
		else
			$display("tensor_permute_address_gen_core verification failed");
		$finish;
	end

endmodule
